@@ rtl/ycr_pkg.sv @@
// Shared types, constants and helpers for the YUV chroma resampler.
// No dependencies; imported by the front, back, top level, checker and bench.
package ycr_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int RESET_WIDTH    = 1920;
    localparam int RESET_HEIGHT   = 1080;
    localparam int CFG_DW         = 13;
    localparam int CFG_AW         = 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int PIX_W          = 24;

    typedef enum logic [CFG_AW-1:0] {
        REG_MODE   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    typedef enum logic {
        MODE_UP   = 1'b0,
        MODE_DOWN = 1'b1
    } mode_t;

    // PASS: chroma carried in the word; STORE: same, and written to the line store;
    // LOAD: chroma comes from the line store
    typedef enum logic [1:0] {
        OP_PASS  = 2'd0,
        OP_STORE = 2'd1,
        OP_LOAD  = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  luma;
        logic [15:0] chroma;   // U high byte, V low byte
        logic        cvalid;
        logic        last;
    } cmd_t;

    // clamp to [2, maxv] and force even
    function automatic int eff_size(input logic [CFG_DW-1:0] v, input int maxv);
        int s;
        s = int'(v);
        if (s < 2)
            s = 2;
        if (s > maxv)
            s = maxv;
        return s & ~1;
    endfunction

endpackage

@@ rtl/ycr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ycr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ycr_queue.sv @@
// Short register FIFO between the front and back halves of the resampler.
// Depends on nothing but its parameters.
module ycr_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNTW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;

    assign not_full  = (count_reg != CNTW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ rtl/ycr_front.sv @@
// Front half: config registers, raster counters, held chroma pair, and
// classification of each accepted pixel into a command. Uses ycr_pkg.
module ycr_front
    import ycr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CW = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH),
    localparam int RW = ($clog2(MAX_HEIGHT) < 1) ? 1 : $clog2(MAX_HEIGHT),
    localparam int LD = MAX_WIDTH / 2,
    localparam int AW = (LD > 1) ? $clog2(LD) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [PIX_W-1:0]  s_axis_tdata,
    input  logic              q_not_full,
    output logic              q_push,
    output cmd_t              cmd,
    output logic [AW-1:0]     slot
);

    localparam int WW = CW + 1;
    localparam int HW = RW + 1;
    localparam logic [WW-1:0] W_RESET =
        WW'(eff_size(CFG_DW'(RESET_WIDTH), MAX_WIDTH));
    localparam logic [HW-1:0] H_RESET =
        HW'(eff_size(CFG_DW'(RESET_HEIGHT), MAX_HEIGHT));

    mode_t         mode_reg, mode_next;
    logic [WW-1:0] w_reg, w_next;
    logic [HW-1:0] h_reg, h_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [15:0]   held_reg, held_next;

    logic          accept;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic          last_col;
    logic          last_row;
    logic          even_col;
    logic          even_row;
    logic [15:0]   pair;

    assign accept        = s_axis_tvalid && q_not_full;
    assign s_axis_tready = q_not_full;
    assign q_push        = accept;

    assign pair     = {s_axis_tdata[15:8], s_axis_tdata[23:16]};
    assign even_col = ~col_reg[0];
    assign even_row = ~row_reg[0];
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign row_inc  = {1'b0, row_reg} + 1'b1;
    // a counter left beyond a shrunk limit wraps as if on the last position
    assign last_col = (col_inc >= w_reg);
    assign last_row = (row_inc >= h_reg);
    assign slot     = col_reg[AW:1];

    // classification
    always_comb
    begin
        cmd.luma   = s_axis_tdata[7:0];
        cmd.last   = last_col && last_row;
        cmd.op     = OP_PASS;
        cmd.chroma = '0;
        cmd.cvalid = 1'b0;
        unique case (mode_reg)
            MODE_UP:
            begin
                cmd.cvalid = 1'b1;
                if (!even_row)
                    cmd.op = OP_LOAD;
                else if (even_col)
                begin
                    cmd.op     = OP_STORE;
                    cmd.chroma = pair;
                end
                else
                    cmd.chroma = held_reg;
            end
            MODE_DOWN:
            begin
                if (even_row && even_col)
                begin
                    cmd.cvalid = 1'b1;
                    cmd.chroma = pair;
                end
            end
            default:
            begin
                cmd.op = OP_PASS;
            end
        endcase
    end

    always_comb
    begin
        mode_next = mode_reg;
        w_next    = w_reg;
        h_next    = h_reg;
        if (cfg_we)
        begin
            if (cfg_addr == REG_MODE)
                mode_next = mode_t'(cfg_wdata[0]);
            else if (cfg_addr == REG_WIDTH)
                w_next = WW'(eff_size(cfg_wdata, MAX_WIDTH));
            else if (cfg_addr == REG_HEIGHT)
                h_next = HW'(eff_size(cfg_wdata, MAX_HEIGHT));
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        held_next = held_reg;
        if (accept)
        begin
            if (mode_reg == MODE_UP && even_row && even_col)
                held_next = pair;
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[RW-1:0];
            end
            else
                col_next = col_inc[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_UP;
            w_reg    <= W_RESET;
            h_reg    <= H_RESET;
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            w_reg    <= w_next;
            h_reg    <= h_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            held_reg <= held_next;
        end
    end

endmodule

@@ rtl/ycr_back.sv @@
// Back half: carries out queued commands against the half-width chroma line
// store and drives the output stream register. Uses ycr_pkg and ycr_ram.
module ycr_back
    import ycr_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int LD = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1,
    localparam int AW = (LD > 1) ? $clog2(LD) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  cmd_t             cmd,
    input  logic [AW-1:0]    slot,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [PIX_W-1:0] m_axis_tdata,
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  luma_reg;
    logic [15:0] chroma_reg;
    logic        load_reg;
    logic        cvalid_reg;
    logic        last_reg;
    logic [15:0] line_rdata;
    logic [15:0] chroma_out;

    // the line store read data stays put until the next pop, so it can feed
    // the held output word directly
    assign q_pop = q_not_empty && (!out_valid_reg || m_axis_tready);

    ycr_ram #(
        .WIDTH (16),
        .DEPTH (LD)
    ) u_line (
        .clk   (clk),
        .we    (q_pop && cmd.op == OP_STORE),
        .waddr (slot),
        .wdata (cmd.chroma),
        .re    (q_pop && cmd.op == OP_LOAD),
        .raddr (slot),
        .rdata (line_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            luma_reg   <= cmd.luma;
            chroma_reg <= cmd.chroma;
            load_reg   <= (cmd.op == OP_LOAD);
            cvalid_reg <= cmd.cvalid;
            last_reg   <= cmd.last;
        end
    end

    assign chroma_out    = load_reg ? line_rdata : chroma_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {chroma_out[7:0], chroma_out[15:8], luma_reg};
    assign m_axis_tuser  = cvalid_reg;
    assign m_axis_tlast  = last_reg;

endmodule

@@ rtl/yuv_chroma_resampler_top.sv @@
// Top level of the YUV 4:2:0 <-> 4:4:4 chroma resampler.
// Uses ycr_pkg, ycr_front, ycr_queue and ycr_back.
//
// Pixels enter in raster order on the s_axis word stream; each accepted word
// gives exactly one word on m_axis, in order. Luma passes straight through.
// mode 0 repeats the chroma pair of each even-row, even-column pixel over its
// 2x2 block, using a line store of MAX_WIDTH/2 pairs; mode 1 keeps only that
// pair and flags all other pixels with tuser low and zero chroma. tlast marks
// the last pixel of the frame.
// Config is a plain write port (cfg_we, cfg_addr, cfg_wdata), written while
// the block is idle: 0 = mode, 1 = frame width, 2 = frame height.
// Throughput is one pixel per clock while m_axis_tready is high. Each word
// accepted goes into the queue, then into the output register; the line store
// is read in the pop cycle and its registered output feeds the result word.
// Reset clears counters, held pair and mode, and sets 1920x1080; the line
// store needs no clearing pass. When the receiver stalls, a four-word queue
// plus the output register absorb input until full, then s_axis_tready drops.
module yuv_chroma_resampler_top
    import ycr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [PIX_W-1:0]  s_axis_tdata,   // luma_in, u_in, v_in
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [PIX_W-1:0]  m_axis_tdata,   // luma_out, u_out, v_out
    output logic              m_axis_tuser,   // chroma_valid
    output logic              m_axis_tlast    // frame_end
);

    localparam int LD = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
    localparam int AW = (LD > 1) ? $clog2(LD) : 1;
    localparam int QW = $bits(cmd_t) + AW;

    cmd_t          f_cmd;
    logic [AW-1:0] f_slot;
    logic          q_push;
    logic          q_not_full;
    logic          q_not_empty;
    logic          q_pop;
    logic [QW-1:0] q_out;
    cmd_t          b_cmd;
    logic [AW-1:0] b_slot;

    ycr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_not_full    (q_not_full),
        .q_push        (q_push),
        .cmd           (f_cmd),
        .slot          (f_slot)
    );

    ycr_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_slot, f_cmd}),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    assign b_cmd  = cmd_t'(q_out[$bits(cmd_t)-1:0]);
    assign b_slot = q_out[QW-1:$bits(cmd_t)];

    ycr_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .cmd           (b_cmd),
        .slot          (b_slot),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ rtl/ycr_checker.sv @@
// Port-level checker for the chroma resampler, bound to the top level.
// Uses ycr_pkg.
module ycr_checker
    import ycr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [PIX_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser,
    input logic             m_axis_tlast
);

    localparam int LIMIT = QUEUE_DEPTH + 1;
    localparam int NW = $clog2(LIMIT + 1);

    logic [NW-1:0] pending_reg, pending_next;
    logic          in_acc;
    logic          out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
            pending_next = pending_reg + 1'b1;
        else if (out_acc && !in_acc)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // stalled output word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // no chroma sample means zero chroma bytes
    a_nochroma: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == 16'd0)
        else $error("chroma bytes set without a chroma sample");

    // every output word stems from an accepted input word
    a_noinvent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != '0)
        else $error("output word with no pending input");

    // queue plus output register full: input must stall
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == NW'(LIMIT) |-> !s_axis_tready)
        else $error("input accepted beyond buffering");

endmodule

bind yuv_chroma_resampler_top ycr_checker u_ycr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for yuv_chroma_resampler_top: scripted and random pixel frames in
// both modes, checked word by word against a cycle-free model of the resampler held in
// the bench. Depends on ycr_pkg and the resampler RTL only.
module tb;
    import ycr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 48;
    localparam int TARGET_PIXELS = 650;
    localparam int QUIET_FROM = 560;
    localparam logic [CFG_AW-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
        logic       cv;
        logic       fe;
    } pix_out_t;

    typedef struct packed {
        logic              is_cfg;
        logic [CFG_AW-1:0] addr;
        logic [CFG_DW-1:0] data;
        logic [7:0]        y;
        logic [7:0]        u;
        logic [7:0]        v;
        logic              typed;
        pix_out_t          want;
    } script_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [PIX_W-1:0]  s_axis_tdata = '0;    // luma_in, u_in, v_in
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [PIX_W-1:0]  m_axis_tdata;         // luma_out, u_out, v_out
    logic              m_axis_tuser;         // chroma_valid
    logic              m_axis_tlast;         // frame_end

    // resampler model state
    mode_t             cur_mode = MODE_UP;
    logic [CFG_DW-1:0] cfg_width = CFG_DW'(RESET_WIDTH);
    logic [CFG_DW-1:0] cfg_height = CFG_DW'(RESET_HEIGHT);
    logic [11:0]       x_pos = '0;
    logic [11:0]       y_pos = '0;
    logic [15:0]       kept_pair = '0;
    logic [15:0]       line_pairs [0:DEF_MAX_WIDTH/2-1];

    pix_out_t    pixel_q [$];
    script_row_t script [$];

    bit idle_on = 1'b1;
    bit sender_gaps = 1'b1;
    bit hold_req = 1'b0;
    int errors = 0;
    int accepted = 0;
    int words_seen = 0;
    int frames_seen = 0;
    int dry_words = 0;
    int cfg_writes = 0;
    int cycle_count = 0;

    yuv_chroma_resampler_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     pixel_q.size());
            $display("tb failed");
            $finish;
        end
    end

    // size as the block sees it: at least 2, at most the limit, even
    function automatic int even_clamp(input logic [CFG_DW-1:0] v, input int limit);
        return (v < 2) ? 2 : (v > limit) ? limit : int'(v & ~13'd1);
    endfunction

    function automatic pix_out_t resample_predict(input logic [7:0] y, u, v);
        int          w;
        int          h;
        logic [10:0] slot;
        logic [15:0] chroma;
        bit          last_col;
        bit          last_row;
        pix_out_t    r;
        w = even_clamp(cfg_width, DEF_MAX_WIDTH);
        h = even_clamp(cfg_height, DEF_MAX_HEIGHT);
        slot = x_pos[11:1];
        chroma = '0;
        r.cv = 1'b0;
        last_col = int'(x_pos) + 1 >= w;
        last_row = int'(y_pos) + 1 >= h;
        if (cur_mode == MODE_UP)
        begin
            r.cv = 1'b1;
            if (!y_pos[0])
            begin
                if (!x_pos[0])
                begin
                    kept_pair = {u, v};
                    line_pairs[slot] = {u, v};
                end
                chroma = kept_pair;
            end
            else
                chroma = line_pairs[slot];
        end
        else if (!y_pos[0] && !x_pos[0])
        begin
            r.cv = 1'b1;
            chroma = {u, v};
        end
        r.y = y;
        r.u = chroma[15:8];
        r.v = chroma[7:0];
        r.fe = last_col && last_row;
        if (last_col)
        begin
            x_pos = '0;
            y_pos = last_row ? 12'd0 : y_pos + 12'd1;
        end
        else
            x_pos = x_pos + 12'd1;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40)
            $display("mismatch on word %0d: %s got %0h want %0h", words_seen, what, got, want);
    endtask

    function automatic void script_cfg(input logic [CFG_AW-1:0] addr,
                                       input logic [CFG_DW-1:0] data);
        script_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.addr = addr;
        row.data = data;
        script = {script, row};
    endfunction

    function automatic void script_pix(input logic [7:0] y, u, v, input logic typed,
                                       input pix_out_t want);
        script_row_t row;
        row = '0;
        row.y = y;
        row.u = u;
        row.v = v;
        row.typed = typed;
        row.want = want;
        script = {script, row};
    endfunction

    task automatic push_pixel(input logic [7:0] y, u, v, input logic typed,
                              input pix_out_t typed_want);
        pix_out_t want;
        if (idle_on && sender_gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {v, u, y};
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = resample_predict(y, u, v);
        pixel_q = {pixel_q, (typed ? typed_want : want)};
        accepted++;
    endtask

    task automatic push_random();
        push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // send at least one pixel, then carry on up to the next frame start
    task automatic finish_frame();
        do
            push_random();
        while (x_pos != 0 || y_pos != 0);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        drain_results();
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            REG_MODE:   cur_mode = mode_t'(data[0]);
            REG_WIDTH:  cfg_width = data;
            REG_HEIGHT: cfg_height = data;
            default:    ;
        endcase
        cfg_writes++;
    endtask

    // output checker
    always @(posedge clk)
    begin : result_check
        pix_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_seen++;
            frames_seen += int'(m_axis_tlast);
            dry_words += int'(!m_axis_tuser);
            if (pixel_q.size() == 0)
                flag_mismatch("unexpected word", int'(m_axis_tdata), 0);
            else
            begin
                want = pixel_q.pop_front();
                if (m_axis_tdata[7:0] !== want.y)
                    flag_mismatch("luma", int'(m_axis_tdata[7:0]), int'(want.y));
                if (m_axis_tdata[15:8] !== want.u)
                    flag_mismatch("u", int'(m_axis_tdata[15:8]), int'(want.u));
                if (m_axis_tdata[23:16] !== want.v)
                    flag_mismatch("v", int'(m_axis_tdata[23:16]), int'(want.v));
                if (m_axis_tuser !== want.cv)
                    flag_mismatch("chroma_valid", int'(m_axis_tuser), int'(want.cv));
                if (m_axis_tlast !== want.fe)
                    flag_mismatch("frame_end", int'(m_axis_tlast), int'(want.fe));
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int n;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                n = HOLD_CYCLES;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 7);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                n = $urandom_range(1, 12);
            end
            repeat (n) @(posedge clk);
        end
    end

    initial
    begin
        int  sel;
        bit  hold_done;
        hold_done = 1'b0;

        // reset defaults, then a 4x2 frame in upsample mode
        script_pix(8'h00, 8'hFF, 8'h00, 1'b1, {8'h00, 8'hFF, 8'h00, 1'b1, 1'b0});
        script_cfg(REG_WIDTH, 13'd4);
        script_cfg(REG_HEIGHT, 13'd2);
        script_pix(8'hFF, 8'h00, 8'hFF, 1'b1, {8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0});
        script_pix(8'h5A, 8'h12, 8'h34, 1'b1, {8'h5A, 8'h12, 8'h34, 1'b1, 1'b0});
        script_pix(8'hA5, 8'h77, 8'h88, 1'b1, {8'hA5, 8'h12, 8'h34, 1'b1, 1'b0});
        script_pix(8'h01, 8'h99, 8'h99, 1'b1, {8'h01, 8'hFF, 8'h00, 1'b1, 1'b0});
        script_pix(8'h80, 8'h00, 8'hFF, 1'b1, {8'h80, 8'hFF, 8'h00, 1'b1, 1'b0});
        script_pix(8'h7F, 8'hFF, 8'hFF, 1'b1, {8'h7F, 8'h12, 8'h34, 1'b1, 1'b0});
        script_pix(8'hC3, 8'h00, 8'h00, 1'b1, {8'hC3, 8'h12, 8'h34, 1'b1, 1'b1});
        // downsample; width shrunk below the column count mid-frame
        script_cfg(REG_MODE, 13'd1);
        script_pix(8'h80, 8'hAB, 8'hCD, 1'b1, {8'h80, 8'hAB, 8'hCD, 1'b1, 1'b0});
        script_pix(8'h11, 8'hFF, 8'hFF, 1'b1, {8'h11, 8'h00, 8'h00, 1'b0, 1'b0});
        script_cfg(REG_WIDTH, 13'd1);
        script_pix(8'h22, 8'h3C, 8'hC3, 1'b1, {8'h22, 8'h3C, 8'hC3, 1'b1, 1'b0});
        script_pix(8'h33, 8'hFF, 8'h00, 1'b1, {8'h33, 8'h00, 8'h00, 1'b0, 1'b0});
        script_pix(8'h44, 8'h00, 8'hFF, 1'b1, {8'h44, 8'h00, 8'h00, 1'b0, 1'b1});
        // clamped sizes, spare index ignored, mode taken from bit 0 only
        script_cfg(REG_HEIGHT, 13'h1FFF);
        script_cfg(REG_WIDTH, 13'd3);
        script_cfg(REG_SPARE, 13'h1FFF);
        script_cfg(REG_MODE, 13'h1FFE);
        repeat (6) script_pix(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 1'b0, '0);
        // height cut to 2 on an odd row past it: wraps at the end of the line
        script_cfg(REG_HEIGHT, 13'd0);
        repeat (2) script_pix(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 1'b0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
                write_reg(script[i].addr, script[i].data);
            else
                push_pixel(script[i].y, script[i].u, script[i].v, script[i].typed,
                           script[i].want);
        end
        if (x_pos != 0 || y_pos != 0)
            finish_frame();

        // every phase starts and ends on a frame boundary, so upsample rows always
        // read line store entries written by the even row above
        while (accepted < TARGET_PIXELS)
        begin
            if (accepted >= QUIET_FROM)
                idle_on = 1'b0;
            sel = $urandom_range(0, 9);
            if (!hold_done && accepted > 200)
            begin
                write_reg(REG_MODE, CFG_DW'($urandom_range(0, 8191)));
                write_reg(REG_WIDTH, 13'd16);
                write_reg(REG_HEIGHT, 13'd4);
                sender_gaps = 1'b0;
                hold_req = 1'b1;
                finish_frame();
                sender_gaps = 1'b1;
                hold_done = 1'b1;
            end
            else if (sel >= 8)
            begin
                // downsample entered mid-frame, then huge and tiny sizes mid-frame
                repeat ($urandom_range(1, 6)) push_random();
                write_reg(REG_MODE, CFG_DW'($urandom_range(0, 8191) | 1));
                repeat ($urandom_range(1, 6)) push_random();
                write_reg(REG_WIDTH, CFG_DW'($urandom_range(0, 8191)));
                write_reg(REG_HEIGHT, CFG_DW'($urandom_range(0, 8191)));
                repeat ($urandom_range(1, 12)) push_random();
                write_reg(REG_WIDTH, CFG_DW'($urandom_range(0, 9)));
                write_reg(REG_HEIGHT, CFG_DW'($urandom_range(0, 5)));
                finish_frame();
            end
            else if (sel == 7)
            begin
                repeat ($urandom_range(1, 5)) push_random();
                drain_results();
                finish_frame();
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_MODE, CFG_DW'($urandom_range(0, 8191)));
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_WIDTH, CFG_DW'($urandom_range(0, 17)));
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_HEIGHT, CFG_DW'($urandom_range(0, 5)));
                repeat ($urandom_range(1, 2)) finish_frame();
            end
        end

        drain_results();
        repeat (8) @(posedge clk);

        $display("covered %0d pixels in %0d frames, %0d words without chroma, %0d reg writes",
                 words_seen, frames_seen, dry_words, cfg_writes);
        $display("%0d mismatches", errors);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
